@@ design/bgc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Transaction types, gesture codes and register indexes.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TimeWidth = 32;
  localparam int CfgWidth = 16;
  localparam int CfgIndexWidth = 3;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP    = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_SHORT  = 3'd3,
    GEST_LONG   = 3'd4
  } gesture_t;

  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_TAP_MIN    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_TAP_MAX    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SHORT      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_LONG       = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_DTAP_WIN   = 3'd5;

  localparam logic [CfgWidth-1:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [CfgWidth-1:0] TAP_MIN_RESET  = 16'd20;
  localparam logic [CfgWidth-1:0] TAP_MAX_RESET  = 16'd300;
  localparam logic [CfgWidth-1:0] SHORT_RESET    = 16'd500;
  localparam logic [CfgWidth-1:0] LONG_RESET     = 16'd1500;
  localparam logic [CfgWidth-1:0] DTAP_WIN_RESET = 16'd400;

  typedef struct packed {
    logic [TimeWidth-1:0] time_now;
    logic                 raw_level;
    logic                 take_gesture;
  } sample_t;

  typedef struct packed {
    gesture_t             gesture;
    logic                 level_clean;
    logic [TimeWidth-1:0] press_hold;
  } result_t;

endpackage

@@ design/button_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// Button gesture classifier
// Debounces a sampled button level and reports taps, double taps, short
// presses and long presses.
//
// Usage:
//   sample channel: one transaction per millisecond sample (time_now,
//     raw_level, take_gesture), accepted when sample_valid is high and
//     sample_stall is low.
//   result channel: one transaction per sample, in order, accepted when
//     result_valid is high and result_stall is low.
//   cfg channel: register writes (cfg_index, cfg_data); cfg_ready is
//     always high. Write only while the block is idle.
// Results are registered. Throughput is one sample per cycle, while
// sample_stall is low, set by the single registered update of gesture state.
// A two-entry output stage (result register plus skid register) takes a
// new sample while a result waits; sample_stall rises only when both hold
// results, and nothing is dropped while the receiver stalls.
// Reset restores the register defaults and clears the gesture state.
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_t                  sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result
);

  result_t result_next;
  result_t skid;
  logic    skid_full;
  logic    sample_fire;
  logic    result_fire;
  logic    out_free;

  assign cfg_ready    = 1'b1;
  assign sample_stall = skid_full;
  assign sample_fire  = sample_valid && !skid_full;
  assign result_fire  = result_valid && !result_stall;
  assign out_free     = !result_valid || result_fire;

  bgc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_fire (sample_fire),
    .sample      (sample),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end else begin
        result_valid <= sample_fire;
      end
    end else if (sample_fire) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= skid_full ? skid : result_next;
    end
    if (!out_free && sample_fire) begin
      skid <= result_next;
    end
  end

  ap_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid holds a transaction with no result in front");

  ap_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && result_valid && result_stall) |=> skid_full)
    else $error("transaction lost while result stalled");

  ap_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !result_stall) |=> (result_valid && !skid_full))
    else $error("skid did not drain");

endmodule

@@ design/bgc_core.sv @@
// ----------------------------------------------------------------------------
// Button gesture classifier core
// Configuration registers, gesture state and the single-pass update that
// turns one sample into one result.
// ----------------------------------------------------------------------------
module bgc_core
  import bgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  input  logic                     sample_fire,
  input  sample_t                  sample,
  output result_t                  result_next
);

  logic [CfgWidth-1:0]  debounce_time;
  logic [CfgWidth-1:0]  tap_min_time;
  logic [CfgWidth-1:0]  tap_max_time;
  logic [CfgWidth-1:0]  short_press_time;
  logic [CfgWidth-1:0]  long_press_time;
  logic [CfgWidth-1:0]  double_tap_window;

  logic                 level_state;
  logic [TimeWidth-1:0] edge_time;
  logic [TimeWidth-1:0] press_start_time;
  logic                 press_active;
  logic [TimeWidth-1:0] first_tap_release_time;
  logic                 awaiting_second_tap;
  gesture_t             pending_code;
  logic                 already_reported;

  logic                 level_state_next;
  logic [TimeWidth-1:0] edge_time_next;
  logic [TimeWidth-1:0] press_start_time_next;
  logic                 press_active_next;
  logic [TimeWidth-1:0] first_tap_release_time_next;
  logic                 awaiting_second_tap_next;
  gesture_t             pending_code_next;
  logic                 already_reported_next;

  logic [TimeWidth-1:0] elapsed;
  logic [TimeWidth-1:0] duration;
  logic [TimeWidth-1:0] tap_gap;
  logic                 accept_change;
  logic                 take_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time     <= DEBOUNCE_RESET;
      tap_min_time      <= TAP_MIN_RESET;
      tap_max_time      <= TAP_MAX_RESET;
      short_press_time  <= SHORT_RESET;
      long_press_time   <= LONG_RESET;
      double_tap_window <= DTAP_WIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_time     <= cfg_data;
        CFG_TAP_MIN:  tap_min_time      <= cfg_data;
        CFG_TAP_MAX:  tap_max_time      <= cfg_data;
        CFG_SHORT:    short_press_time  <= cfg_data;
        CFG_LONG:     long_press_time   <= cfg_data;
        CFG_DTAP_WIN: double_tap_window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign elapsed       = sample.time_now - edge_time;
  assign duration      = sample.time_now - press_start_time;
  assign tap_gap       = press_start_time - first_tap_release_time;
  assign accept_change = (sample.raw_level != level_state) &&
                         (elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_time});

  always_comb begin
    level_state_next            = level_state;
    edge_time_next              = edge_time;
    press_start_time_next       = press_start_time;
    press_active_next           = press_active;
    first_tap_release_time_next = first_tap_release_time;
    awaiting_second_tap_next    = awaiting_second_tap;
    pending_code_next           = pending_code;
    already_reported_next       = already_reported;
    result_next.gesture         = GEST_NONE;

    if (accept_change) begin
      level_state_next = sample.raw_level;
      edge_time_next   = sample.time_now;
      if (sample.raw_level) begin
        press_start_time_next = sample.time_now;
        press_active_next     = 1'b1;
        pending_code_next     = GEST_NONE;
        already_reported_next = 1'b0;
      end else if (press_active) begin
        press_active_next = 1'b0;
        if (duration >= {{(TimeWidth-CfgWidth){1'b0}}, long_press_time}) begin
          pending_code_next        = GEST_LONG;
          already_reported_next    = 1'b0;
          awaiting_second_tap_next = 1'b0;
        end else if (duration >= {{(TimeWidth-CfgWidth){1'b0}}, short_press_time}) begin
          pending_code_next        = GEST_SHORT;
          already_reported_next    = 1'b0;
          awaiting_second_tap_next = 1'b0;
        end else if (duration >= {{(TimeWidth-CfgWidth){1'b0}}, tap_min_time} &&
                     duration <= {{(TimeWidth-CfgWidth){1'b0}}, tap_max_time}) begin
          already_reported_next = 1'b0;
          if (awaiting_second_tap &&
              tap_gap <= {{(TimeWidth-CfgWidth){1'b0}}, double_tap_window}) begin
            pending_code_next        = GEST_DOUBLE;
            awaiting_second_tap_next = 1'b0;
          end else begin
            pending_code_next           = GEST_TAP;
            first_tap_release_time_next = sample.time_now;
            awaiting_second_tap_next    = 1'b1;
          end
        end
      end
    end

    take_ok = sample.take_gesture && !already_reported_next &&
              (pending_code_next != GEST_NONE);
    if (take_ok) begin
      already_reported_next = 1'b1;
      result_next.gesture   = pending_code_next;
    end

    result_next.level_clean = level_state_next;
    result_next.press_hold  = press_active_next ? (sample.time_now - press_start_time_next)
                                                : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_state            <= 1'b0;
      edge_time              <= '0;
      press_start_time       <= '0;
      press_active           <= 1'b0;
      first_tap_release_time <= '0;
      awaiting_second_tap    <= 1'b0;
      pending_code           <= GEST_NONE;
      already_reported       <= 1'b1;
    end else if (sample_fire) begin
      level_state            <= level_state_next;
      edge_time              <= edge_time_next;
      press_start_time       <= press_start_time_next;
      press_active           <= press_active_next;
      first_tap_release_time <= first_tap_release_time_next;
      awaiting_second_tap    <= awaiting_second_tap_next;
      pending_code           <= pending_code_next;
      already_reported       <= already_reported_next;
    end
  end

  ap_press_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && accept_change && sample.raw_level) |=>
      (press_active && pending_code == GEST_NONE))
    else $error("press did not start timing");

  ap_taken_once: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && result_next.gesture != GEST_NONE) |=> already_reported)
    else $error("taken gesture not marked reported");

  ap_hold_zero_released: assert property (@(posedge clk) disable iff (rst)
    (!press_active_next && result_next.press_hold != '0) |-> 1'b0)
    else $error("hold time nonzero while released");

endmodule
